/* rtl/aac_pkg.sv */
// ----------------------------------------------------------------------------
// aac_pkg
// Shared types and constants of the analog axis conditioner.
// ----------------------------------------------------------------------------
package aac_pkg;

	localparam int AXIS_W      = 11;  // axis values 0..1024, config registers
	localparam int COEFF_W     = 9;   // Q1.8 smoothing coefficient, up to 511
	localparam int COEFF_SHIFT = 8;
	localparam int CFG_IDX_W   = 3;

	localparam logic [AXIS_W-1:0]  FULL_SCALE     = 11'd1024;
	localparam logic [COEFF_W-1:0] FAST_COEFF     = 9'd230;
	localparam logic [AXIS_W-1:0]  RST_CAL_MAX    = 11'd1024;
	localparam logic [COEFF_W-1:0] RST_SLOW_COEFF = 9'd26;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DZ_MIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DZ_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DZ_VALUE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_COEFF = 3'd5;

	// divider operand source
	typedef enum logic {
		DIV_MAP,
		DIV_DZ
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     map_eval;
		logic     shape_eval;
		logic     shape_fin;
		logic     filt_mul;
		logic     filt_upd;
	} aac_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic dz_div;
	} aac_sts_t;

endpackage

/* rtl/analog_axis_conditioner.sv */
// ----------------------------------------------------------------------------
// analog_axis_conditioner
// Calibrates, deadzone-shapes and exponentially smooths one axis reading.
// ----------------------------------------------------------------------------
// One item is processed at a time. Each item uses the single shared
// restoring divider, one quotient bit per cycle, once for the calibration
// map and once more when the sample needs a rescale below or above the
// deadzone. The divider works on NUM_W = max(SAMPLE_BITS, 11) + 11 bits.
// A finished result waits in the output register while the next item is
// accepted; the block only stalls before writing a new result if the
// previous one has not yet been taken. Registers are written through
// cfg_we/cfg_index/cfg_data and should only change while no item is in work.
// ----------------------------------------------------------------------------
module analog_axis_conditioner #(
	parameter int SAMPLE_BITS   = 10,
	parameter int FRACTION_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aac_pkg::AXIS_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [SAMPLE_BITS-1:0]        raw_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [aac_pkg::AXIS_W-1:0]    axis_value,
	output logic [aac_pkg::AXIS_W-1:0]    shaped_sample
);

	import aac_pkg::*;

	aac_cmd_t cmd;
	aac_sts_t sts;

	aac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	aac_dp #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.raw_sample   (raw_sample),
		.cmd          (cmd),
		.sts          (sts),
		.axis_value   (axis_value),
		.shaped_sample(shaped_sample)
	);

endmodule

/* rtl/aac_div.sv */
// ----------------------------------------------------------------------------
// aac_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aac_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] acc_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, acc_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign busy  = cnt_q != '0;
	assign quot  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			// remainder stays below den, so the low DEN_W bits hold it
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			acc_q <= {acc_q[NUM_W-2:0], ge};
		end
	end

endmodule

/* rtl/aac_dp.sv */
// ----------------------------------------------------------------------------
// aac_dp
// Datapath: config registers, calibration map, deadzone shaping, smoothing
// filter and output registers. Sequenced by aac_ctrl.
// ----------------------------------------------------------------------------
module aac_dp #(
	parameter int SAMPLE_BITS   = 10,
	parameter int FRACTION_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [aac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aac_pkg::AXIS_W-1:0]     cfg_data,
	input  logic [SAMPLE_BITS-1:0]         raw_sample,
	input  aac_pkg::aac_cmd_t              cmd,
	output aac_pkg::aac_sts_t              sts,
	output logic [aac_pkg::AXIS_W-1:0]     axis_value,
	output logic [aac_pkg::AXIS_W-1:0]     shaped_sample
);

	import aac_pkg::*;

	localparam int MAG_W    = (SAMPLE_BITS > AXIS_W) ? SAMPLE_BITS : AXIS_W;
	localparam int NUM_W    = MAG_W + AXIS_W;
	localparam int SMOOTH_W = AXIS_W + FRACTION_BITS;
	localparam int PROD_W   = SMOOTH_W + COEFF_W;
	localparam logic [SMOOTH_W-1:0] FAST_THRESH = SMOOTH_W'(3) << (FRACTION_BITS - 1);
	localparam logic [SMOOTH_W-1:0] SMOOTH_TOP  = SMOOTH_W'(FULL_SCALE) << FRACTION_BITS;

	typedef enum logic [1:0] {
		SH_INSIDE,
		SH_BELOW,
		SH_ABOVE,
		SH_PASS
	} shape_t;

	// config registers
	logic [AXIS_W-1:0]  cal_min_q, cal_max_q, dz_min_q, dz_max_q, dz_value_q;
	logic [COEFF_W-1:0] slow_coeff_q;

	// item registers
	logic [SAMPLE_BITS-1:0] raw_q;
	logic                   map_neg_q;
	logic [AXIS_W-1:0]      v_q;
	shape_t                 shape_q;
	logic                   dz_neg_q;
	logic [NUM_W-1:0]       dz_num_q;
	logic [AXIS_W-1:0]      dz_den_q;
	logic [AXIS_W-1:0]      shaped_q;
	logic [PROD_W-1:0]      filt_prod_q;
	logic                   d_neg_q;
	logic [SMOOTH_W-1:0]    smoothed_q;
	logic [AXIS_W-1:0]      axis_q;
	logic [AXIS_W-1:0]      shaped_out_q;

	// divider
	logic [NUM_W-1:0]  div_num;
	logic [AXIS_W-1:0] div_den;
	logic              div_busy;
	logic [NUM_W-1:0]  div_quot;

	// calibration map
	logic [MAG_W-1:0]  raw_x, lo_x, map_mag;
	logic              raw_lt, cal_rev;
	logic [AXIS_W-1:0] cal_span;
	logic [NUM_W-1:0]  map_num;
	logic [AXIS_W-1:0] map_v;

	// deadzone
	shape_t              shape_v;
	logic [AXIS_W-1:0]   mul_a, mul_b, hi_span, dz_den_v;
	logic [2*AXIS_W-1:0] dz_prod;
	logic [AXIS_W-1:0]   dzv_sat, quot_sat, above_neg, shaped_v;
	logic [NUM_W:0]      above_sum;

	// filter
	logic [SMOOTH_W-1:0] target, d_mag, smooth_next;
	logic                d_neg;
	logic [COEFF_W-1:0]  coeff;
	logic [SMOOTH_W:0]   step;
	logic [SMOOTH_W+1:0] smooth_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_q    <= '0;
			cal_max_q    <= RST_CAL_MAX;
			dz_min_q     <= '0;
			dz_max_q     <= '0;
			dz_value_q   <= '0;
			slow_coeff_q <= RST_SLOW_COEFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAL_MIN:    cal_min_q    <= cfg_data;
				CFG_CAL_MAX:    cal_max_q    <= cfg_data;
				CFG_DZ_MIN:     dz_min_q     <= cfg_data;
				CFG_DZ_MAX:     dz_max_q     <= cfg_data;
				CFG_DZ_VALUE:   dz_value_q   <= cfg_data;
				CFG_SLOW_COEFF: slow_coeff_q <= cfg_data[COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	// --- calibration map: |raw - lo| * 1025 / |hi - lo|, sign kept aside ---
	assign raw_x    = MAG_W'(raw_q);
	assign lo_x     = MAG_W'(cal_min_q);
	assign raw_lt   = raw_x < lo_x;
	assign map_mag  = raw_lt ? (lo_x - raw_x) : (raw_x - lo_x);
	assign map_num  = (NUM_W'(map_mag) << 10) + NUM_W'(map_mag);
	assign cal_rev  = cal_max_q < cal_min_q;
	assign cal_span = cal_rev ? (cal_min_q - cal_max_q) : (cal_max_q - cal_min_q);

	// negative quotients and equal bounds both end at zero after the clamp
	always_comb begin
		if (cal_min_q == cal_max_q || map_neg_q) begin
			map_v = '0;
		end else if (div_quot > NUM_W'(FULL_SCALE)) begin
			map_v = FULL_SCALE;
		end else begin
			map_v = div_quot[AXIS_W-1:0];
		end
	end

	always_comb begin
		unique case (cmd.div_sel)
			DIV_MAP: begin
				div_num = map_num;
				div_den = cal_span;
			end
			DIV_DZ: begin
				div_num = dz_num_q;
				div_den = dz_den_q;
			end
			default: begin
				div_num = map_num;
				div_den = cal_span;
			end
		endcase
	end

	aac_div #(
		.NUM_W(NUM_W),
		.DEN_W(AXIS_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quot  (div_quot)
	);

	// --- deadzone classification and rescale operands ---
	always_comb begin
		priority if (v_q > dz_min_q && v_q < dz_max_q) begin
			shape_v = SH_INSIDE;
		end else if (v_q < dz_min_q) begin
			shape_v = SH_BELOW;
		end else if (v_q > dz_max_q) begin
			shape_v = SH_ABOVE;
		end else begin
			shape_v = SH_PASS;
		end
	end

	assign hi_span  = (dz_value_q > FULL_SCALE) ? (dz_value_q - FULL_SCALE)
	                                            : (FULL_SCALE - dz_value_q);
	assign mul_a    = (shape_v == SH_BELOW) ? v_q : (v_q - dz_max_q);
	assign mul_b    = (shape_v == SH_BELOW) ? dz_value_q : hi_span;
	assign dz_den_v = (shape_v == SH_BELOW) ? dz_min_q : (FULL_SCALE - dz_max_q);
	assign dz_prod  = (2*AXIS_W)'(mul_a) * (2*AXIS_W)'(mul_b);

	// --- deadzone result ---
	assign dzv_sat   = (dz_value_q > FULL_SCALE) ? FULL_SCALE : dz_value_q;
	assign quot_sat  = (div_quot > NUM_W'(FULL_SCALE)) ? FULL_SCALE
	                                                  : div_quot[AXIS_W-1:0];
	assign above_sum = (NUM_W+1)'(div_quot) + (NUM_W+1)'(dz_value_q);
	// quotient below dz_value here, so the low bits give the difference
	assign above_neg = dz_value_q - div_quot[AXIS_W-1:0];

	always_comb begin
		unique case (shape_q)
			SH_INSIDE: shaped_v = dzv_sat;
			SH_BELOW:  shaped_v = quot_sat;
			SH_ABOVE: begin
				if (dz_neg_q) begin
					if (div_quot >= NUM_W'(dz_value_q)) begin
						shaped_v = '0;
					end else begin
						shaped_v = (above_neg > FULL_SCALE) ? FULL_SCALE : above_neg;
					end
				end else begin
					shaped_v = (above_sum > (NUM_W+1)'(FULL_SCALE)) ? FULL_SCALE
					                                                : above_sum[AXIS_W-1:0];
				end
			end
			SH_PASS:   shaped_v = v_q;
			default:   shaped_v = v_q;
		endcase
	end

	// --- smoothing filter ---
	assign target = {shaped_q, {FRACTION_BITS{1'b0}}};
	assign d_neg  = target < smoothed_q;
	assign d_mag  = d_neg ? (smoothed_q - target) : (target - smoothed_q);
	assign coeff  = (d_mag > FAST_THRESH) ? FAST_COEFF : slow_coeff_q;
	assign step   = filt_prod_q[PROD_W-1:COEFF_SHIFT];
	assign smooth_sum = (SMOOTH_W+2)'(smoothed_q) + (SMOOTH_W+2)'(step);

	always_comb begin
		if (d_neg_q) begin
			if (step >= {1'b0, smoothed_q}) begin
				smooth_next = '0;
			end else begin
				smooth_next = smoothed_q - step[SMOOTH_W-1:0];
			end
		end else if (smooth_sum > (SMOOTH_W+2)'(SMOOTH_TOP)) begin
			smooth_next = SMOOTH_TOP;
		end else begin
			smooth_next = smooth_sum[SMOOTH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
		end else if (cmd.filt_upd) begin
			smoothed_q <= smooth_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q <= raw_sample;
		end
		if (cmd.div_start && cmd.div_sel == DIV_MAP) begin
			map_neg_q <= raw_lt ^ cal_rev;
		end
		if (cmd.map_eval) begin
			v_q <= map_v;
		end
		if (cmd.shape_eval) begin
			shape_q  <= shape_v;
			dz_num_q <= NUM_W'(dz_prod);
			dz_den_q <= dz_den_v;
			dz_neg_q <= (shape_v == SH_ABOVE) && (dz_value_q > FULL_SCALE);
		end
		if (cmd.shape_fin) begin
			shaped_q <= shaped_v;
		end
		if (cmd.filt_mul) begin
			filt_prod_q <= PROD_W'(d_mag) * PROD_W'(coeff);
			d_neg_q     <= d_neg;
		end
		if (cmd.filt_upd) begin
			axis_q       <= smooth_next[SMOOTH_W-1:FRACTION_BITS];
			shaped_out_q <= shaped_q;
		end
	end

	assign sts.div_busy   = div_busy;
	assign sts.dz_div     = (shape_q == SH_BELOW) || (shape_q == SH_ABOVE);
	assign axis_value     = axis_q;
	assign shaped_sample  = shaped_out_q;

endmodule

/* rtl/aac_ctrl.sv */
// ----------------------------------------------------------------------------
// aac_ctrl
// Sequencer for one item at a time, plus the output valid flag.
// ----------------------------------------------------------------------------
module aac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  aac_pkg::aac_sts_t sts,
	output aac_pkg::aac_cmd_t cmd
);

	import aac_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_MAP_WAIT,
		ST_CLAMP,
		ST_SHAPE,
		ST_DZ_DIV,
		ST_DZ_WAIT,
		ST_DZ_FIN,
		ST_FILT_MUL,
		ST_FILT_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new item replaces one taken in the same cycle
			if (state_q == ST_FILT_UPD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:     if (in_valid) state_q <= ST_MAP;
				ST_MAP:      state_q <= ST_MAP_WAIT;
				ST_MAP_WAIT: if (!sts.div_busy) state_q <= ST_CLAMP;
				ST_CLAMP:    state_q <= ST_SHAPE;
				ST_SHAPE:    state_q <= ST_DZ_DIV;
				ST_DZ_DIV:   state_q <= sts.dz_div ? ST_DZ_WAIT : ST_DZ_FIN;
				ST_DZ_WAIT:  if (!sts.div_busy) state_q <= ST_DZ_FIN;
				ST_DZ_FIN:   state_q <= ST_FILT_MUL;
				ST_FILT_MUL: state_q <= ST_FILT_UPD;
				ST_FILT_UPD: begin
					// hold until the output register can take the item
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.div_sel    = (state_q == ST_MAP) ? DIV_MAP : DIV_DZ;
		cmd.load       = (state_q == ST_IDLE) && in_valid;
		cmd.div_start  = (state_q == ST_MAP) || ((state_q == ST_DZ_DIV) && sts.dz_div);
		cmd.map_eval   = state_q == ST_CLAMP;
		cmd.shape_eval = state_q == ST_SHAPE;
		cmd.shape_fin  = state_q == ST_DZ_FIN;
		cmd.filt_mul   = state_q == ST_FILT_MUL;
		cmd.filt_upd   = (state_q == ST_FILT_UPD) && out_free;
	end

endmodule
